>>> sv/abrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrf_pkg
// Shared types, codes and helpers for the banked register file unit.
// ----------------------------------------------------------------------------
package abrf_pkg;

    // Default data word width
    localparam int WORD_WIDTH_DEF = 32;

    // Physical store sizes
    localparam int REG_COUNT  = 32;
    localparam int REG_IDX_W  = $clog2(REG_COUNT);
    localparam int SPSR_COUNT = 5;
    localparam int SPSR_IDX_W = $clog2(SPSR_COUNT);

    // CPSR value after reset: Supervisor, IRQ and FIQ masked
    localparam logic [7:0] CPSR_RESET = 8'hD3;

    // Mode field encodings (CPSR bits 4:0)
    localparam logic [4:0] MODE_USR = 5'h10;
    localparam logic [4:0] MODE_FIQ = 5'h11;
    localparam logic [4:0] MODE_IRQ = 5'h12;
    localparam logic [4:0] MODE_SVC = 5'h13;
    localparam logic [4:0] MODE_ABT = 5'h17;
    localparam logic [4:0] MODE_UND = 5'h1B;
    localparam logic [4:0] MODE_SYS = 5'h1F;

    // Access operations
    typedef enum logic [1:0] {
        OP_READ_REG  = 2'd0,
        OP_WRITE_REG = 2'd1,
        OP_READ_PSR  = 2'd2,
        OP_WRITE_PSR = 2'd3
    } t_op;

    // Result error codes
    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_NO_SPSR  = 2'd1,
        ERR_BAD_MODE = 2'd2
    } t_err;

    // Banking class of the current mode
    typedef enum logic [1:0] {
        KIND_USER = 2'd0,
        KIND_FIQ  = 2'd1,
        KIND_PAIR = 2'd2,
        KIND_BAD  = 2'd3
    } t_kind;

    // Decoded mode: banking class, SPSR slot and first banked entry
    typedef struct packed {
        t_kind                 kind;
        logic [SPSR_IDX_W-1:0] spsr_idx;
        logic [REG_IDX_W-1:0]  base;
    } t_mode_info;

    // Write controls and addresses towards the store
    typedef struct packed {
        logic                  reg_we;
        logic [REG_IDX_W-1:0]  reg_idx;
        logic                  spsr_we;
        logic [SPSR_IDX_W-1:0] spsr_idx;
        logic                  cpsr_we;
    } t_store_cmd;

    // Map an architectural register to its physical entry
    function automatic logic [REG_IDX_W-1:0] phys_index(
        input t_kind                kind,
        input logic [REG_IDX_W-1:0] base,
        input logic [3:0]           r
    );
        logic [REG_IDX_W-1:0] r_ext;
        r_ext = REG_IDX_W'(r);
        if (kind == KIND_FIQ && (r inside {[4'd8:4'd14]})) begin
            phys_index = base + r_ext - REG_IDX_W'(8);
        end else if (kind == KIND_PAIR && (r inside {4'd13, 4'd14})) begin
            phys_index = base + r_ext - REG_IDX_W'(13);
        end else begin
            phys_index = r_ext;
        end
    endfunction

endpackage

>>> sv/abrf_mode_dec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrf_mode_dec
// Decodes the CPSR mode field into banking class, SPSR slot and bank base.
// ----------------------------------------------------------------------------
module abrf_mode_dec (
    input  logic [4:0]          i_mode,
    output abrf_pkg::t_mode_info o_info
);
    import abrf_pkg::*;

    // Mode lookup
    always_comb begin
        o_info = '{kind: KIND_BAD, spsr_idx: '0, base: '0};
        case (i_mode)
            MODE_USR, MODE_SYS: begin
                o_info.kind = KIND_USER;
            end
            MODE_FIQ: begin
                o_info = '{kind: KIND_FIQ, spsr_idx: SPSR_IDX_W'(4), base: REG_IDX_W'(24)};
            end
            MODE_SVC: begin
                o_info = '{kind: KIND_PAIR, spsr_idx: SPSR_IDX_W'(0), base: REG_IDX_W'(16)};
            end
            MODE_ABT: begin
                o_info = '{kind: KIND_PAIR, spsr_idx: SPSR_IDX_W'(1), base: REG_IDX_W'(18)};
            end
            MODE_UND: begin
                o_info = '{kind: KIND_PAIR, spsr_idx: SPSR_IDX_W'(2), base: REG_IDX_W'(20)};
            end
            MODE_IRQ: begin
                o_info = '{kind: KIND_PAIR, spsr_idx: SPSR_IDX_W'(3), base: REG_IDX_W'(22)};
            end
            default: begin
                o_info.kind = KIND_BAD;
            end
        endcase
    end

endmodule

>>> sv/abrf_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrf_store
// Physical register bank and saved status slots, cleared at reset, and the CPSR, loaded with its reset value.
// ----------------------------------------------------------------------------
module abrf_store #(
    parameter int WORD_WIDTH = abrf_pkg::WORD_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  abrf_pkg::t_store_cmd  i_cmd,
    input  logic [WORD_WIDTH-1:0] i_wdata,
    output logic [WORD_WIDTH-1:0] o_reg_rdata,
    output logic [WORD_WIDTH-1:0] o_spsr_rdata,
    output logic [WORD_WIDTH-1:0] o_cpsr
);
    import abrf_pkg::*;

    logic [WORD_WIDTH-1:0] r_regs [REG_COUNT];
    logic [WORD_WIDTH-1:0] r_spsr [SPSR_COUNT];
    logic [WORD_WIDTH-1:0] r_cpsr;

    // Register bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= '0;
            end
        end else if (i_cmd.reg_we) begin
            r_regs[i_cmd.reg_idx] <= i_wdata;
        end
    end

    // Saved status slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SPSR_COUNT; i++) begin
                r_spsr[i] <= '0;
            end
        end else if (i_cmd.spsr_we && i_cmd.spsr_idx < SPSR_IDX_W'(SPSR_COUNT)) begin
            r_spsr[i_cmd.spsr_idx] <= i_wdata;
        end
    end

    // Current status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpsr <= WORD_WIDTH'(CPSR_RESET);
        end else if (i_cmd.cpsr_we) begin
            r_cpsr <= i_wdata;
        end
    end

    // Read ports
    assign o_reg_rdata  = r_regs[i_cmd.reg_idx];
    assign o_spsr_rdata = (i_cmd.spsr_idx < SPSR_IDX_W'(SPSR_COUNT))
                          ? r_spsr[i_cmd.spsr_idx] : '0;
    assign o_cpsr       = r_cpsr;

endmodule

>>> sv/arm_banked_register_file_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_banked_register_file_unit
// Mode-banked register file with CPSR/SPSR access, one access per cycle.
// ----------------------------------------------------------------------------
//  channel   | handshake          | words
//  ----------+--------------------+------------------------------------------
//  access in | start, busy        | i_op, i_reg_number, i_write_data
//  result    | o_valid (strobe)   | o_read_data, o_error_code
//
//  One access is taken every cycle; busy stays low.
//  Each access passes the input register, then decode and store access into
//  the result register. Each access sees the state left by the one before.
//  Synchronous reset clears the bank and SPSRs and loads CPSR with 0xD3. The
//  result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module arm_banked_register_file_unit #(
    parameter int WORD_WIDTH = abrf_pkg::WORD_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_op,
    input  logic [3:0]            i_reg_number,
    input  logic [WORD_WIDTH-1:0] i_write_data,
    output logic                  o_valid,
    output logic [WORD_WIDTH-1:0] o_read_data,
    output logic [1:0]            o_error_code
);
    import abrf_pkg::*;

    // Input register
    logic                  r_in_valid;
    t_op                   r_op;
    logic [3:0]            r_reg_num;
    logic [WORD_WIDTH-1:0] r_wdata;

    // Result register
    logic                  r_out_valid;
    logic [WORD_WIDTH-1:0] r_rdata;
    t_err                  r_err;
    logic [WORD_WIDTH-1:0] n_rdata;
    t_err                  n_err;

    t_mode_info            mode;
    t_store_cmd            cmd;
    logic [WORD_WIDTH-1:0] reg_rdata;
    logic [WORD_WIDTH-1:0] spsr_rdata;
    logic [WORD_WIDTH-1:0] cpsr;

    assign busy = 1'b0;

    // Capture each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= t_op'(i_op);
        r_reg_num <= i_reg_number;
        r_wdata   <= i_write_data;
    end

    // Current mode from CPSR
    abrf_mode_dec u_mode_dec (
        .i_mode (cpsr[4:0]),
        .o_info (mode)
    );

    // Access control: route to bank, SPSR or CPSR and flag bad accesses
    always_comb begin
        n_rdata      = '0;
        n_err        = ERR_OK;
        cmd          = '0;
        cmd.reg_idx  = phys_index(mode.kind, mode.base, r_reg_num);
        cmd.spsr_idx = mode.spsr_idx;
        case (r_op)
            OP_READ_REG, OP_WRITE_REG: begin
                if (mode.kind == KIND_BAD) begin
                    n_err = ERR_BAD_MODE;
                end else if (r_op == OP_READ_REG) begin
                    n_rdata = reg_rdata;
                end else begin
                    cmd.reg_we = r_in_valid;
                end
            end
            OP_READ_PSR, OP_WRITE_PSR: begin
                if (!r_reg_num[0]) begin
                    if (r_op == OP_READ_PSR) begin
                        n_rdata = cpsr;
                    end else begin
                        cmd.cpsr_we = r_in_valid;
                    end
                end else if (mode.kind == KIND_BAD) begin
                    n_err = ERR_BAD_MODE;
                end else if (mode.kind == KIND_USER) begin
                    n_err = ERR_NO_SPSR;
                end else if (r_op == OP_READ_PSR) begin
                    n_rdata = spsr_rdata;
                end else begin
                    cmd.spsr_we = r_in_valid;
                end
            end
            default: begin
                n_err = ERR_OK;
            end
        endcase
        // idle slots present zeros
        if (!r_in_valid) begin
            n_rdata = '0;
            n_err   = ERR_OK;
        end
    end

    // State store
    abrf_store #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_wdata      (r_wdata),
        .o_reg_rdata  (reg_rdata),
        .o_spsr_rdata (spsr_rdata),
        .o_cpsr       (cpsr)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_rdata     <= '0;
            r_err       <= ERR_OK;
        end else begin
            r_out_valid <= r_in_valid;
            r_rdata     <= n_rdata;
            r_err       <= n_err;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_data  = r_rdata;
    assign o_error_code = r_err;

endmodule

>>> sv/abrf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrf_checker
// Port-level checks on the banked register file unit, bound to the top level.
// ----------------------------------------------------------------------------
module abrf_checker #(
    parameter int WORD_WIDTH = abrf_pkg::WORD_WIDTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [1:0]            i_op,
    input logic [3:0]            i_reg_number,
    input logic                  o_valid,
    input logic [WORD_WIDTH-1:0] o_read_data,
    input logic [1:0]            o_error_code
);
    import abrf_pkg::*;

    // Every result word stems from an earlier accepted access
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result without a matching access");

    // Every access out of reset yields a result
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(start && !busy, 2) && $past(i_rst_n, 1) && $past(i_rst_n, 2))
        |-> o_valid)
        else $error("access lost");

    // Flagged accesses return zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_code != ERR_OK) |-> o_read_data == '0)
        else $error("flagged access returned data");

    // Writes return zero data
    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(start && !busy && (i_op == OP_WRITE_REG
                                         || i_op == OP_WRITE_PSR), 2))
        |-> o_read_data == '0)
        else $error("write returned data");

    // A CPSR access is never flagged
    a_cpsr_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(start && !busy && !i_reg_number[0]
                          && (i_op == OP_READ_PSR || i_op == OP_WRITE_PSR), 2))
        |-> o_error_code == ERR_OK)
        else $error("CPSR access flagged");

endmodule

bind arm_banked_register_file_unit abrf_checker #(
    .WORD_WIDTH (WORD_WIDTH)
) u_abrf_checker (.*);

>>> dv/tb_arm_banked_register_file_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arm_banked_register_file_unit
// Self-checking bench for the mode-banked register file: access words are
// fed in bursts and checked against a behavioural copy of the register banks,
// the SPSRs and the CPSR. A directed opening covers the mode cases. Random
// traffic follows, mostly in valid modes.
// ----------------------------------------------------------------------------
module tb_arm_banked_register_file_unit;
    import abrf_pkg::*;

    localparam int W          = WORD_WIDTH_DEF;
    localparam int RAND_WORDS = 1025;
    localparam int STALL_MAX  = 200;

    // Expected outcome of one access
    typedef struct {
        logic [W-1:0] rdata;
        t_err         err;
    } t_access_outcome;

    // Shadow of the banked store plus queue of outcomes still to come
    class regfile_scoreboard;
        logic [W-1:0]    bank_regs [REG_COUNT];
        logic [W-1:0]    spsr_bank [SPSR_COUNT];
        logic [W-1:0]    cpsr_val;
        t_access_outcome outcome_q[$];
        int              failures;

        function new();
            foreach (bank_regs[k]) bank_regs[k] = '0;
            foreach (spsr_bank[k]) spsr_bank[k] = '0;
            cpsr_val = W'(CPSR_RESET);
            failures = 0;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        // Banking class, SPSR slot and first banked entry of the current mode
        function void decode_mode(output t_kind kind, output int slot, output int base);
            slot = 0;
            base = 0;
            case (cpsr_val[4:0])
                MODE_USR, MODE_SYS: kind = KIND_USER;
                MODE_FIQ: begin kind = KIND_FIQ;  slot = 4; base = 24; end
                MODE_SVC: begin kind = KIND_PAIR; slot = 0; base = 16; end
                MODE_ABT: begin kind = KIND_PAIR; slot = 1; base = 18; end
                MODE_UND: begin kind = KIND_PAIR; slot = 2; base = 20; end
                MODE_IRQ: begin kind = KIND_PAIR; slot = 3; base = 22; end
                default:  kind = KIND_BAD;
            endcase
        endfunction

        // Apply one accepted access word and queue its outcome
        function void note_access(t_op op, logic [3:0] r, logic [W-1:0] d);
            t_kind           kind;
            int              slot;
            int              base;
            int              idx;
            t_access_outcome res;
            decode_mode(kind, slot, base);
            res.rdata = '0;
            res.err   = ERR_OK;
            if (op == OP_READ_REG || op == OP_WRITE_REG) begin
                if (kind == KIND_BAD) begin
                    res.err = ERR_BAD_MODE;
                end else begin
                    idx = int'(r);
                    if (kind == KIND_FIQ && r >= 4'd8 && r <= 4'd14)
                        idx = base + int'(r) - 8;
                    else if (kind == KIND_PAIR && (r == 4'd13 || r == 4'd14))
                        idx = base + int'(r) - 13;
                    if (op == OP_READ_REG) res.rdata = bank_regs[idx];
                    else                   bank_regs[idx] = d;
                end
            end else if (!r[0]) begin
                // CPSR: taken in every mode, bad ones included
                if (op == OP_READ_PSR) res.rdata = cpsr_val;
                else                   cpsr_val = d;
            end else if (kind == KIND_BAD) begin
                res.err = ERR_BAD_MODE;
            end else if (kind == KIND_USER) begin
                res.err = ERR_NO_SPSR;
            end else begin
                if (op == OP_READ_PSR) res.rdata = spsr_bank[slot];
                else                   spsr_bank[slot] = d;
            end
            outcome_q.push_back(res);
        endfunction

        // Compare one result word with the oldest outcome
        function void check_result(logic [W-1:0] rdata, logic [1:0] err);
            t_access_outcome exp_res;
            if (outcome_q.size() == 0) begin
                $error("unexpected result: read_data %h error_code %0d", rdata, err);
                failures++;
                return;
            end
            exp_res = outcome_q.pop_front();
            if (rdata !== exp_res.rdata) begin
                $error("read_data: expected %h, got %h", exp_res.rdata, rdata);
                failures++;
            end
            if (err !== exp_res.err) begin
                $error("error_code: expected %0d, got %0d", exp_res.err, err);
                failures++;
            end
        endfunction
    endclass

    logic         i_clk        = 1'b0;
    logic         i_rst_n      = 1'b0;
    logic         start        = 1'b0;
    logic         busy;
    logic [1:0]   i_op         = OP_READ_REG;
    logic [3:0]   i_reg_number = 4'd0;
    logic [W-1:0] i_write_data = '0;
    logic         o_valid;
    logic [W-1:0] o_read_data;
    logic [1:0]   o_error_code;

    regfile_scoreboard sb = new();
    int                stall_cycles = 0;

    arm_banked_register_file_unit #(.WORD_WIDTH(W)) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_reg_number (i_reg_number),
        .i_write_data (i_write_data),
        .o_valid      (o_valid),
        .o_read_data  (o_read_data),
        .o_error_code (o_error_code)
    );

    always #5 i_clk = ~i_clk;

    // Monitor and watchdog: inputs and outputs seen as they were before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_access(t_op'(i_op), i_reg_number, i_write_data);
            if (o_valid)
                sb.check_result(o_read_data, o_error_code);
        end
        if ((start && !busy) || o_valid) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_MAX) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Present one access word and hold it until taken
    task automatic send_access(input t_op op, input logic [3:0] r, input logic [W-1:0] d);
        @(negedge i_clk);
        start        <= 1'b1;
        i_op         <= op;
        i_reg_number <= r;
        i_write_data <= d;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // Hold off until every queued outcome has come back
    task automatic drain();
        idle_cycles(1);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [4:0] valid_mode(input int k);
        case (k)
            0:       return MODE_USR;
            1:       return MODE_FIQ;
            2:       return MODE_IRQ;
            3:       return MODE_SVC;
            4:       return MODE_ABT;
            5:       return MODE_UND;
            default: return MODE_SYS;
        endcase
    endfunction

    function automatic logic [W-1:0] rand_data();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return W'($urandom);
    endfunction

    // One random access word; CPSR writes mostly land on a valid mode
    task automatic send_random();
        int           pick;
        logic [W-1:0] d;
        pick = $urandom_range(0, 99);
        d    = rand_data();
        if (pick < 8) begin
            if ($urandom_range(0, 99) < 85)
                d[4:0] = valid_mode($urandom_range(0, 6));
            send_access(OP_WRITE_PSR, {3'($urandom_range(0, 7)), 1'b0}, d);
        end else if (pick < 14) begin
            send_access(OP_WRITE_PSR, {3'($urandom_range(0, 7)), 1'b1}, d);
        end else if (pick < 22) begin
            send_access(OP_READ_PSR, 4'($urandom_range(0, 15)), d);
        end else begin
            send_access($urandom_range(0, 1) ? OP_WRITE_REG : OP_READ_REG,
                        4'($urandom_range(0, 15)), d);
        end
    endtask

    initial begin
        int sent;
        int burst;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset values, svc banking, user SPSR, fiq bank, bad mode
        send_access(OP_READ_PSR,  4'd0,  '0);
        send_access(OP_READ_PSR,  4'd1,  '1);
        send_access(OP_WRITE_REG, 4'd13, '1);
        send_access(OP_WRITE_REG, 4'd14, 32'hA5A5_5A5A);
        send_access(OP_READ_REG,  4'd13, '0);
        send_access(OP_WRITE_REG, 4'd0,  '1);
        send_access(OP_WRITE_PSR, 4'd15, 32'h1234_5678);
        send_access(OP_WRITE_PSR, 4'd14, {27'h5555_555, MODE_USR});
        send_access(OP_READ_REG,  4'd13, '0);
        send_access(OP_READ_PSR,  4'd1,  '0);
        send_access(OP_WRITE_PSR, 4'd3,  '1);
        send_access(OP_WRITE_PSR, 4'd2,  {27'h7800_006, MODE_FIQ});
        send_access(OP_WRITE_REG, 4'd8,  32'hDEAD_BEEF);
        send_access(OP_READ_REG,  4'd8,  '0);
        send_access(OP_READ_REG,  4'd15, '0);
        // Undefined mode code: banks and SPSR refused, CPSR still usable
        send_access(OP_WRITE_PSR, 4'd0,  '0);
        send_access(OP_READ_REG,  4'd0,  '0);
        send_access(OP_WRITE_REG, 4'd0,  32'h0BAD_0BAD);
        send_access(OP_READ_PSR,  4'd1,  '0);
        send_access(OP_READ_PSR,  4'd0,  '1);
        send_access(OP_WRITE_PSR, 4'd0,  '1);
        send_access(OP_READ_REG,  4'd0,  '0);
        send_access(OP_READ_PSR,  4'd9,  '0);
        send_access(OP_WRITE_PSR, 4'd0,  W'(CPSR_RESET));
        send_access(OP_READ_PSR,  4'd1,  '0);
        drain();

        // Random traffic in bursts, back to back or with gaps
        sent = 0;
        while (sent < RAND_WORDS) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                send_random();
                sent++;
            end
            if (sent >= RAND_WORDS / 2 && sent - burst < RAND_WORDS / 2)
                drain();
            else if ($urandom_range(0, 9) >= 3)
                idle_cycles($urandom_range(1, 8));
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
